// ===== design/rctb_pkg.sv =====
package rctb_pkg;

  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int MAX_ENTRIES = 1024;
  localparam int STEP_W      = 24;

  localparam logic [31:0]      SEED_RESET  = 32'h1234_5678;
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [1:0] FUNC_GEN   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CHASE = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [2:0] ADDR_SEED  = 3'd0;
  localparam logic [2:0] ADDR_COUNT = 3'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  start_index;
    logic [STEP_W-1:0] step_count;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [1:0]       status;
  } result_t;

endpackage

// ===== design/random_cycle_table_builder_unit.sv =====
// Random single-cycle successor table. Issue a transaction with start while
// busy is low; the result on result is marked by done, high for exactly
// one cycle, and cannot be held off, so capture it when done is high. A
// generate fills the permutation store, shuffles it with one xorshift32
// draw and one remainder per entry (draw, a 4-bit-per-cycle remainder unit,
// read and two single-port writes), then links the cycle with a read of the
// permutation and a write of the successor memory. A read and a chase wait
// on the registered read of the successor memory, a chase once per hop.
// Errors, a zero-hop chase and the unused function code finish straight
// from idle. No clearing pass.
module random_cycle_table_builder_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rctb_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done,
  output rctb_pkg::result_t    result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IW = rctb_pkg::IDX_W;
  localparam int CW = rctb_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_DRAW, S_MOD, S_SWAP_RD, S_SWAP_W1, S_SWAP_W2,
    S_LINK_RD, S_LINK_WR, S_RD_RD, S_RD_DONE, S_CH_RD, S_CH_NX
  } state_t;

  state_t state;

  // config registers
  logic [31:0]   seed;
  logic [CW-1:0] entry_count;
  logic          cfg_wr;

  // working registers
  logic [31:0]             rng;
  logic                    table_ready;
  logic [CW-1:0]           gen_count;
  logic [IW-1:0]           pos;        // fill/link index or shuffle position
  logic [IW-1:0]           j_idx;
  logic [31:0]             mod_word;
  logic [CW-1:0]           mod_rem;
  logic [2:0]              mod_cnt;
  logic [IW-1:0]           rd_a;
  logic [IW-1:0]           rd_b;
  logic [IW-1:0]           sd;
  logic [IW-1:0]           cur;
  logic [rctb_pkg::STEP_W-1:0] hops;

  // memories
  logic [IW-1:0] perm [rctb_pkg::MAX_ENTRIES];
  logic [IW-1:0] succ [rctb_pkg::MAX_ENTRIES];

  logic          perm_we;
  logic [IW-1:0] perm_wa, perm_wd, perm_ra, perm_rb;
  logic          perm_re;
  logic          succ_we;
  logic          succ_re;

  logic [31:0]   x1, x2, x3;
  logic [CW-1:0] divisor;
  logic [CW-1:0] rem_next;
  logic [CW-1:0] n_clamp;
  logic [IW-1:0] last_pos;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state != S_IDLE);

  always_comb begin
    prdata = 32'd0;
    if (paddr[2]) begin
      prdata = {{(32-CW){1'b0}}, entry_count};
    end else begin
      prdata = seed;
    end
  end

  // next generator word
  always_comb begin
    x1 = rng ^ (rng << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
  end

  // remainder unit: four dividend bits per cycle, MSB first
  assign divisor = {1'b0, pos} + CW'(1);
  always_comb begin
    logic [CW:0] t;
    rem_next = mod_rem;
    for (int b = 0; b < 4; b++) begin
      t = {rem_next, mod_word[31-b]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[CW-1:0];
    end
  end

  always_comb begin
    n_clamp = entry_count;
    if (entry_count < CW'(2)) begin
      n_clamp = CW'(2);
    end else if (entry_count > CW'(rctb_pkg::MAX_ENTRIES)) begin
      n_clamp = CW'(rctb_pkg::MAX_ENTRIES);
    end
  end
  assign last_pos = IW'(gen_count - CW'(1));

  // memory port control
  always_comb begin
    perm_we = 1'b0;
    perm_wa = pos;
    perm_wd = pos;
    perm_re = 1'b0;
    perm_ra = pos;
    perm_rb = j_idx;
    succ_we = 1'b0;
    succ_re = 1'b0;
    case (state)
      S_FILL: begin
        perm_we = 1'b1;
      end
      S_SWAP_RD: begin
        perm_re = 1'b1;
      end
      S_SWAP_W1: begin
        perm_we = 1'b1;
        perm_wd = rd_b;
      end
      S_SWAP_W2: begin
        perm_we = 1'b1;
        perm_wa = j_idx;
        perm_wd = rd_a;
      end
      S_LINK_RD: begin
        perm_re = 1'b1;
        perm_rb = (pos == last_pos) ? '0 : pos + IW'(1);
      end
      S_LINK_WR: begin
        succ_we = 1'b1;
      end
      S_RD_RD, S_CH_RD: begin
        succ_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm[perm_wa] <= perm_wd;
    end
    if (perm_re) begin
      rd_a <= perm[perm_ra];
      rd_b <= perm[perm_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ[rd_a] <= rd_b;
    end
    if (succ_re) begin
      sd <= succ[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seed        <= rctb_pkg::SEED_RESET;
      entry_count <= rctb_pkg::COUNT_RESET;
      rng         <= rctb_pkg::SEED_RESET;
      table_ready <= 1'b0;
      gen_count   <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2]) begin
          entry_count <= pwdata[CW-1:0];
        end else begin
          seed <= pwdata;
          rng  <= pwdata;
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur  <= cmd.start_index;
            hops <= cmd.step_count;
            case (cmd.func)
              rctb_pkg::FUNC_GEN: begin
                result    <= '{result_index: '0, status: rctb_pkg::ST_OK};
                gen_count <= n_clamp;
                pos       <= '0;
                state     <= S_FILL;
              end
              rctb_pkg::FUNC_READ, rctb_pkg::FUNC_CHASE: begin
                if (!table_ready) begin
                  result <= '{result_index: '0, status: rctb_pkg::ST_NOT_READY};
                  done   <= 1'b1;
                end else if ({1'b0, cmd.start_index} >= gen_count) begin
                  result <= '{result_index: '0, status: rctb_pkg::ST_RANGE};
                  done   <= 1'b1;
                end else if (cmd.func == rctb_pkg::FUNC_READ) begin
                  state <= S_RD_RD;
                end else if (cmd.step_count == '0) begin
                  // zero hops: return the start index
                  result <= '{result_index: cmd.start_index, status: rctb_pkg::ST_OK};
                  done   <= 1'b1;
                end else begin
                  state <= S_CH_RD;
                end
              end
              default: begin
                result <= '{result_index: '0, status: rctb_pkg::ST_OK};
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_FILL: begin
          // write identity, then shuffle from the top entry down
          if (pos == last_pos) begin
            state <= S_DRAW;
          end else begin
            pos <= pos + IW'(1);
          end
        end
        S_DRAW: begin
          rng      <= x3;
          mod_word <= x3;
          mod_rem  <= '0;
          mod_cnt  <= '0;
          state    <= S_MOD;
        end
        S_MOD: begin
          mod_rem  <= rem_next;
          mod_word <= mod_word << 4;
          mod_cnt  <= mod_cnt + 3'd1;
          if (mod_cnt == 3'd7) begin
            j_idx <= IW'(rem_next);
            state <= S_SWAP_RD;
          end
        end
        S_SWAP_RD: begin
          state <= S_SWAP_W1;
        end
        S_SWAP_W1: begin
          state <= S_SWAP_W2;
        end
        S_SWAP_W2: begin
          if (pos == IW'(1)) begin
            pos   <= '0;
            state <= S_LINK_RD;
          end else begin
            pos   <= pos - IW'(1);
            state <= S_DRAW;
          end
        end
        S_LINK_RD: begin
          state <= S_LINK_WR;
        end
        S_LINK_WR: begin
          if (pos == last_pos) begin
            table_ready <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            pos   <= pos + IW'(1);
            state <= S_LINK_RD;
          end
        end
        S_RD_RD: begin
          state <= S_RD_DONE;
        end
        S_RD_DONE: begin
          result <= '{result_index: sd, status: rctb_pkg::ST_OK};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_CH_RD: begin
          state <= S_CH_NX;
        end
        S_CH_NX: begin
          // advance one hop
          cur  <= sd;
          hops <= hops - rctb_pkg::STEP_W'(1);
          if (hops == rctb_pkg::STEP_W'(1)) begin
            result <= '{result_index: sd, status: rctb_pkg::ST_OK};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_CH_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a finished multi-cycle transaction always reports
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("busy dropped without a result");

  // unused function code answers on the next cycle
  a_unused: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.func == rctb_pkg::FUNC_SPARE) |=> (done && !busy))
    else $error("unused function code did not finish at once");

  // shuffle draws stay below the current divisor
  a_jrange: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_RD) |-> (j_idx <= pos))
    else $error("shuffle index above position");

endmodule
